// ===== sv/ple_pkg.sv =====
// Shared constants, types and command/status structs for the positional list engine.
package ple_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [STAT_W-1:0] stat_t;

  localparam op_t OP_INSERT = 3'd0;
  localparam op_t OP_DELETE = 3'd1;
  localparam op_t OP_LOCATE = 3'd2;
  localparam op_t OP_GET    = 3'd3;
  localparam op_t OP_CLEAR  = 3'd4;

  localparam stat_t ST_OK    = 2'd0;
  localparam stat_t ST_RANGE = 2'd1;
  localparam stat_t ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic check;
    logic walk;
    logic tail;
    logic put;
    logic out_load;
  } ple_cmd_t;

  typedef struct packed {
    logic go_walk;
    logic go_put;
    logic walk_last;
    logic loc_hit;
    logic is_insert;
    logic out_free;
  } ple_sts_t;

endpackage

// ===== sv/positional_list_engine.sv =====
// Positional list engine: insert/delete/locate/get/clear on a 1-based ordered list.
// Clear, unused codes, refusals and locate on an empty list go from the check straight to the
// result; get, locate and delete walk the element RAM first; insert at the tail writes at once,
// else it shifts entries in a walk, then writes. The walk makes one element RAM access per cycle.
// The next request is taken in the cycle after a result loads, even while that result waits.
// Synchronous active-high rst empties the list and drops any pending result; RAM not cleared.
module positional_list_engine
  import ple_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  op_t   operation,
  input  pos_t  position,
  input  val_t  value,
  output logic  out_valid,
  input  logic  out_stall,
  output stat_t status,
  output val_t  read_value,
  output pos_t  found_position,
  output pos_t  count,
  output logic  is_empty
);

  ple_cmd_t cmd;
  ple_sts_t sts;

  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ple_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .position       (position),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .count          (count),
    .is_empty       (is_empty)
  );

endmodule

// ===== sv/ple_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ple_datapath.sv =====
// Datapath: request registers, length count, element RAM walk and result register.
module ple_datapath
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ple_cmd_t cmd,
  output ple_sts_t sts,
  input  op_t      operation,
  input  pos_t     position,
  input  val_t     value,
  output logic     out_valid,
  input  logic     out_stall,
  output stat_t    status,
  output val_t     read_value,
  output pos_t     found_position,
  output pos_t     count,
  output logic     is_empty
);

  op_t   op_r;
  pos_t  pos_r;
  val_t  val_r;
  len_t  len;
  addr_t idx;
  addr_t prev;
  logic  pend;
  stat_t stat_r;
  val_t  rd_r;
  pos_t  found_r;

  logic  ram_we;
  addr_t ram_waddr;
  val_t  ram_wdata;
  val_t  ram_rdata;

  logic  is_ins, is_del, is_loc, is_get, is_clr;
  pos_t  len_p, pos_dec;
  len_t  len_dec;
  addr_t pos_addr, len_last;
  logic  bad_ins, bad_rd, full, ins_ok, ins_end, walking, match;

  assign is_ins = (op_r == OP_INSERT);
  assign is_del = (op_r == OP_DELETE);
  assign is_loc = (op_r == OP_LOCATE);
  assign is_get = (op_r == OP_GET);
  assign is_clr = (op_r == OP_CLEAR);

  assign len_p    = pos_t'(len);
  assign pos_dec  = pos_r - pos_t'(1);
  assign len_dec  = len - len_t'(1);
  assign pos_addr = pos_dec[ADDR_W-1:0];
  assign len_last = len_dec[ADDR_W-1:0];

  assign bad_ins = (pos_r == '0) || (pos_r > len_p + pos_t'(1));
  assign bad_rd  = (pos_r == '0) || (pos_r > len_p);
  assign full    = (len == len_t'(CAPACITY));
  assign ins_ok  = is_ins && !bad_ins && !full;
  assign ins_end = (pos_r == len_p + pos_t'(1));
  assign walking = (cmd.walk || cmd.tail) && pend;
  assign match   = (ram_rdata == val_r);

  assign sts.go_walk   = (ins_ok && !ins_end) || ((is_del || is_get) && !bad_rd) ||
                         (is_loc && (len != '0));
  assign sts.go_put    = ins_ok && ins_end;
  assign sts.walk_last = is_get || (is_ins && (idx == pos_addr)) ||
                         ((is_del || is_loc) && (idx == len_last));
  assign sts.loc_hit   = is_loc && pend && match;
  assign sts.is_insert = is_ins;
  assign sts.out_free  = !out_valid || !out_stall;

  // Insert moves entries up (read idx, write prev+1); delete moves them down
  // (write prev-1), except the first read, which is the deleted element.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = prev - addr_t'(1);
    ram_wdata = ram_rdata;
    if (cmd.put) begin
      ram_we    = 1'b1;
      ram_waddr = pos_addr;
      ram_wdata = val_r;
    end else if (walking && is_ins) begin
      ram_we    = 1'b1;
      ram_waddr = prev + addr_t'(1);
    end else if (walking && is_del && (prev != pos_addr)) begin
      ram_we    = 1'b1;
    end
  end

  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= operation;
      pos_r <= position;
      val_r <= value;
    end
    if (cmd.check) begin
      rd_r    <= '0;
      found_r <= '0;
      if (is_ins && bad_ins) begin
        stat_r <= ST_RANGE;
      end else if (is_ins && full) begin
        stat_r <= ST_FULL;
      end else if ((is_del || is_get) && bad_rd) begin
        stat_r <= ST_RANGE;
      end else begin
        stat_r <= ST_OK;
      end
      if (is_ins) begin
        idx <= len_last;
      end else if (is_loc) begin
        idx <= '0;
      end else begin
        idx <= pos_addr;
      end
    end
    if (cmd.walk) begin
      prev <= idx;
      idx  <= is_ins ? idx - addr_t'(1) : idx + addr_t'(1);
    end
    if (walking) begin
      if (is_get || (is_del && (prev == pos_addr))) begin
        rd_r <= ram_rdata;
      end
      if (is_loc && match) begin
        found_r <= pos_t'(prev) + pos_t'(1);
      end
    end
    if (cmd.out_load) begin
      status         <= stat_r;
      read_value     <= rd_r;
      found_position <= found_r;
      count          <= len_p;
      is_empty       <= (len == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.check) begin
        pend <= 1'b0;
        if (is_clr) begin
          len <= '0;
        end
      end
      if (cmd.walk) begin
        pend <= 1'b1;
      end
      if (cmd.tail && is_del) begin
        len <= len_dec;
      end
      if (cmd.put) begin
        len <= len + len_t'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTH
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    len <= len_t'(CAPACITY))
    else $error("list length above capacity");

  a_put_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.put |=> len == $past(len) + len_t'(1))
    else $error("insert did not grow the list by one");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result register loaded over a pending result");

  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    (ram_we && is_ins) |-> !full)
    else $error("insert write while list full");
`endif

endmodule

// ===== sv/ple_ctrl.sv =====
// Controller: sequences check, RAM walk, final write and result transfer per request.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  ple_sts_t sts,
  output ple_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_WALK   = 6'b000100,
    S_TAIL   = 6'b001000,
    S_PUT    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.go_walk) begin
          state_next = S_WALK;
        end else if (sts.go_put) begin
          state_next = S_PUT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.loc_hit) begin
          state_next = S_FINISH;
        end else if (sts.walk_last) begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.tail   = 1'b1;
        state_next = sts.is_insert ? S_PUT : S_FINISH;
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
